// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // request kinds carried in the request beat's tuser
   typedef enum logic [2:0] {
      REQ_STREAM    = 3'd0,
      REQ_CHAR_AT   = 3'd1,
      REQ_SET_CUR   = 3'd2,
      REQ_CLEAR     = 3'd3,
      REQ_FILL      = 3'd4,
      REQ_READ_CELL = 3'd5
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SCROLL_PRIME,
      ST_SCROLL_MOVE,
      ST_SCROLL_BLANK,
      ST_FILL,
      ST_RESP
   } tcw_state_type;

   localparam logic [7:0]  CHAR_NL     = 8'h0A;
   localparam logic [7:0]  CHAR_CR     = 8'h0D;
   localparam logic [7:0]  CHAR_BLANK  = 8'h20;
   localparam logic [7:0]  RESET_COLOR = 8'h1F;
   localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CHAR_BLANK};

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int CELL_W      = 16;
   localparam int CUR_ROW_W   = 5;
   localparam int CUR_COL_W   = 7;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// text-mode console engine: cell store, cursor, scroll, clear, fill, read
// ----------------------------------------------------------------------------
// usage:
//   req_* takes one request per beat; tuser holds the request kind, tdata the
//   row, column, character and colors. every request gives exactly one rsp_*
//   beat with the cell read (zero unless a read) and the cursor after it.
//   csr_* writes the text color; write it only while no request is in flight.
//   req_tready is high only in idle: one request is worked at a time.
//   characters, cursor moves and position writes go from the exec state
//   straight to the response; an in-range cell read adds a state for the
//   registered memory read. a newline or line wrap on the last row scrolls:
//   the store copies one cell per cycle after a read prime, then blanks
//   the last row; clear and fill sweep the store one cell per cycle.
//   after reset the store is swept to blank on blue, during which req_tready
//   stays low (csr writes are taken).
//   when rsp_tready is low the finished result holds in the output register;
//   the next request is still taken but its result waits until that beat
//   has left.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_core #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: row[7:0], col[15:8], ch[23:16], fg[27:24], bg[31:28]
   input  wire logic [tcw_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: req_type[2:0]
   input  wire logic [2:0]                       req_tuser,
   // response
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: cell_data[15:0], cursor_row[20:16], cursor_col[27:21], zero above
   output logic [tcw_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // text color register
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [7:0]                       csr_wdata
);

   import tcw_pkg::*;

   `include "assert_macros.svh"

   localparam int NCELLS = ROWS * COLS;
   localparam int AW     = $clog2(NCELLS);
   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);

   localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST   = CW'(COLS - 1);
   localparam logic [8:0]    ROWS_LIM   = 9'(ROWS);
   localparam logic [8:0]    COLS_LIM   = 9'(COLS);
   localparam logic [AW-1:0] CELL_LAST  = AW'(NCELLS - 1);
   localparam logic [AW-1:0] MOVE_LAST  = AW'(NCELLS - COLS - 1);
   localparam logic [AW-1:0] COLS_AW    = AW'(COLS);

   // ---- registers
   tcw_state_type           state_ff, state_in;
   logic [RW-1:0]           cur_row_ff, cur_row_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in;
   logic [AW-1:0]           walk_ptr_ff, walk_ptr_in;
   logic [7:0]              text_color_ff, text_color_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [CELL_W-1:0]       data_ff, data_in;
   logic [CELL_W-1:0]       fill_cell_ff, fill_cell_in;
   req_kind_type            kind_ff, kind_in;
   logic [7:0]              row_ff, row_in;
   logic [7:0]              col_ff, col_in;
   logic [7:0]              ch_ff, ch_in;
   logic [7:0]              attr_ff, attr_in;

   // ---- cell store
   logic [CELL_W-1:0]       mem [NCELLS];
   logic [CELL_W-1:0]       mem_rdata_ff;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [CELL_W-1:0]       mem_wdata;
   logic                    mem_re;
   logic [AW-1:0]           mem_raddr;

   // ---- shared address unit
   logic                    use_req_pos;
   logic [RW-1:0]           sel_row;
   logic [CW-1:0]           sel_col;
   logic [AW-1:0]           cell_idx;
   logic [AW-1:0]           walk_inc;
   logic [AW-1:0]           scroll_src;
   logic                    pos_ok;
   logic                    req_beat;

   assign req_beat   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pos_ok      = ({1'b0, row_ff} < ROWS_LIM) && ({1'b0, col_ff} < COLS_LIM);
   assign use_req_pos = (kind_ff == REQ_CHAR_AT) || (kind_ff == REQ_READ_CELL);
   assign sel_row     = use_req_pos ? RW'(row_ff) : cur_row_ff;
   assign sel_col     = use_req_pos ? CW'(col_ff) : cur_col_ff;
   assign cell_idx    = AW'(sel_row) * COLS_AW + AW'(sel_col);
   assign walk_inc    = walk_ptr_ff + AW'(1);
   // source row lies one screen row below the destination
   assign scroll_src  = ((state_ff == ST_SCROLL_MOVE) ? walk_inc : walk_ptr_ff) + COLS_AW;

   always_comb begin
      logic line_break;
      logic is_nl;
      logic is_cr;

      state_in      = state_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      walk_ptr_in   = walk_ptr_ff;
      text_color_in = text_color_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      data_in       = data_ff;
      fill_cell_in  = fill_cell_ff;
      kind_in       = kind_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      ch_in         = ch_ff;
      attr_in       = attr_ff;

      mem_we    = 1'b0;
      mem_waddr = walk_ptr_ff;
      mem_wdata = fill_cell_ff;
      mem_re    = 1'b0;
      mem_raddr = scroll_src;

      is_nl      = (ch_ff == CHAR_NL);
      is_cr      = (ch_ff == CHAR_CR);
      line_break = is_nl || (!is_cr && (cur_col_ff == COL_LAST));

      if (csr_valid && csr_ready) begin
         text_color_in = csr_wdata;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = RESET_CELL;
            if (walk_ptr_ff == CELL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               walk_ptr_in = walk_inc;
            end
         end

         ST_IDLE: begin
            if (req_beat) begin
               kind_in  = req_kind_type'(req_tuser);
               row_in   = req_tdata[7:0];
               col_in   = req_tdata[15:8];
               ch_in    = req_tdata[23:16];
               attr_in  = {req_tdata[31:28], req_tdata[27:24]};
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            data_in     = '0;
            walk_ptr_in = '0;
            state_in    = ST_RESP;
            mem_raddr   = cell_idx;
            case (kind_ff)
               REQ_STREAM: begin
                  if (!is_nl && !is_cr) begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_idx;
                     mem_wdata = {text_color_ff, ch_ff};
                  end
                  if (line_break) begin
                     cur_col_in = '0;
                     if (cur_row_ff == ROW_LAST) begin
                        state_in = ST_SCROLL_PRIME;
                     end else begin
                        cur_row_in = cur_row_ff + RW'(1);
                     end
                  end else if (is_cr) begin
                     cur_col_in = '0;
                  end else begin
                     cur_col_in = cur_col_ff + CW'(1);
                  end
               end
               REQ_CHAR_AT: begin
                  if (pos_ok) begin
                     mem_we    = 1'b1;
                     mem_waddr = cell_idx;
                     mem_wdata = {attr_ff, ch_ff};
                  end
               end
               REQ_SET_CUR: begin
                  cur_row_in = ({1'b0, row_ff} < ROWS_LIM) ? RW'(row_ff) : ROW_LAST;
                  cur_col_in = ({1'b0, col_ff} < COLS_LIM) ? CW'(col_ff) : COL_LAST;
               end
               REQ_CLEAR: begin
                  fill_cell_in = {text_color_ff, CHAR_BLANK};
                  cur_row_in   = '0;
                  cur_col_in   = '0;
                  state_in     = ST_FILL;
               end
               REQ_FILL: begin
                  fill_cell_in = {attr_ff, CHAR_BLANK};
                  state_in     = ST_FILL;
               end
               REQ_READ_CELL: begin
                  if (pos_ok) begin
                     mem_re   = 1'b1;
                     state_in = ST_READ;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_READ: begin
            data_in  = mem_rdata_ff;
            state_in = ST_RESP;
         end

         ST_SCROLL_PRIME: begin
            mem_re   = 1'b1;
            state_in = ST_SCROLL_MOVE;
         end

         ST_SCROLL_MOVE: begin
            // read data is the cell one row below walk_ptr
            mem_we      = 1'b1;
            mem_wdata   = mem_rdata_ff;
            walk_ptr_in = walk_inc;
            if (walk_ptr_ff == MOVE_LAST) begin
               state_in = ST_SCROLL_BLANK;
            end else begin
               mem_re = 1'b1;
            end
         end

         ST_SCROLL_BLANK: begin
            mem_we    = 1'b1;
            mem_wdata = {text_color_ff, CHAR_BLANK};
            if (walk_ptr_ff == CELL_LAST) begin
               state_in = ST_RESP;
            end else begin
               walk_ptr_in = walk_inc;
            end
         end

         ST_FILL: begin
            mem_we = 1'b1;
            if (walk_ptr_ff == CELL_LAST) begin
               state_in = ST_RESP;
            end else begin
               walk_ptr_in = walk_inc;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_TDATA_W'({CUR_COL_W'(cur_col_ff),
                                            CUR_ROW_W'(cur_row_ff), data_ff});
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cur_row_ff    <= '0;
         cur_col_ff    <= '0;
         walk_ptr_ff   <= '0;
         text_color_ff <= RESET_COLOR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         walk_ptr_ff   <= walk_ptr_in;
         text_color_ff <= text_color_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      data_ff      <= data_in;
      fill_cell_ff <= fill_cell_in;
      kind_ff      <= kind_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      ch_ff        <= ch_in;
      attr_ff      <= attr_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   // ---- checks
   `ASSERT_HOLDS(a_cursor_in_range, clock, reset,
      (cur_row_ff <= ROW_LAST) && (cur_col_ff <= COL_LAST))
   `ASSERT_NEXT(a_beat_starts_exec, clock, reset,
      req_beat, state_ff == ST_EXEC)
   `ASSERT_IMPLIES(a_scroll_on_last_row, clock, reset,
      (state_ff == ST_SCROLL_MOVE) || (state_ff == ST_SCROLL_BLANK),
      (cur_row_ff == ROW_LAST) && (cur_col_ff == '0))
   `ASSERT_NEXT(a_resp_loads_output, clock, reset,
      (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready),
      rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

// ===== tb/tb_text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// self-checking bench for the text console writer: a local copy of the cell
// store and cursor predicts every response beat, which is compared field by
// field as it leaves the block; directed cases, color register sweeps,
// output stalls and a long random run with random idling on both streams
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_console_writer_core;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   localparam int ROWS       = 25;
   localparam int COLS       = 80;
   localparam int NCELLS     = ROWS * COLS;
   localparam int STALL_MAX  = 20000;
   localparam int TAIL_WAIT  = 16;
   localparam int HOLD_LONG  = 300;
   localparam int RAND_ITEMS = 1300;

   // request codes the block has no name for, they must be ignored
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   typedef struct packed {
      logic [15:0] cell_val;
      logic [4:0]  crow;
      logic [6:0]  ccol;
   } cell_report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = REQ_STREAM;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_wdata  = '0;

   // local copy of the console
   logic [15:0]  screen [NCELLS];
   int unsigned  cur_row;
   int unsigned  cur_col;
   logic [7:0]   text_color;

   cell_report_type cell_report_q[$];
   int              mismatches    = 0;
   bit              no_idle       = 1'b0;
   int              rsp_hold_left = 0;
   int              stall_cycles  = 0;

   text_console_writer_core #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- console
   function automatic void console_reset();
      text_color = RESET_COLOR;
      cur_row    = 0;
      cur_col    = 0;
      for (int i = 0; i < NCELLS; i++) screen[i] = RESET_CELL;
   endfunction

   function automatic void console_newline();
      cur_col = 0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (int i = 0; i < NCELLS - COLS; i++) screen[i] = screen[i + COLS];
         for (int i = NCELLS - COLS; i < NCELLS; i++) screen[i] = {text_color, CHAR_BLANK};
         cur_row = ROWS - 1;
      end
   endfunction

   function automatic cell_report_type console_step(logic [2:0] kind, logic [7:0] row,
                                                    logic [7:0] col, logic [7:0] ch,
                                                    logic [3:0] fg, logic [3:0] bg);
      cell_report_type rep;
      logic [7:0]      attr;
      bit              in_range;
      attr         = {bg, fg};
      in_range     = (row < ROWS) && (col < COLS);
      rep.cell_val = '0;
      case (kind)
         REQ_STREAM: begin
            if (ch == CHAR_NL) begin
               console_newline();
            end else if (ch == CHAR_CR) begin
               cur_col = 0;
            end else begin
               screen[cur_row * COLS + cur_col] = {text_color, ch};
               cur_col++;
               if (cur_col >= COLS) console_newline();
            end
         end
         REQ_CHAR_AT: begin
            if (in_range) screen[row * COLS + col] = {attr, ch};
         end
         REQ_SET_CUR: begin
            cur_row = (row < ROWS) ? row : ROWS - 1;
            cur_col = (col < COLS) ? col : COLS - 1;
         end
         REQ_CLEAR: begin
            for (int i = 0; i < NCELLS; i++) screen[i] = {text_color, CHAR_BLANK};
            cur_row = 0;
            cur_col = 0;
         end
         REQ_FILL: begin
            for (int i = 0; i < NCELLS; i++) screen[i] = {attr, CHAR_BLANK};
         end
         REQ_READ_CELL: begin
            if (in_range) rep.cell_val = screen[row * COLS + col];
         end
         default: begin
         end
      endcase
      rep.crow = cur_row[4:0];
      rep.ccol = cur_col[6:0];
      return rep;
   endfunction

   // ---------------------------------------------------------------- drivers
   task automatic send_req(input logic [2:0] kind, input logic [7:0] row,
                           input logic [7:0] col, input logic [7:0] ch,
                           input logic [3:0] fg, input logic [3:0] bg);
      while (!no_idle && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {bg, fg, ch, col, row};
      do @(posedge clock); while (!req_tready);
      cell_report_q.push_back(console_step(kind, row, col, ch, fg, bg));
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (cell_report_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_color(input logic [7:0] color);
      wait_results_drained();
      csr_valid <= 1'b1;
      csr_wdata <= color;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      text_color = color;
   endtask

   function automatic logic [7:0] pick_row();
      return ($urandom_range(99) < 80) ? 8'($urandom_range(ROWS - 1)) : 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_col();
      return ($urandom_range(99) < 80) ? 8'($urandom_range(COLS - 1)) : 8'($urandom_range(255));
   endfunction

   task automatic send_random_req();
      int unsigned pick;
      logic [2:0]  kind;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  ch;
      pick = $urandom_range(999);
      row  = pick_row();
      col  = pick_col();
      ch   = 8'($urandom_range(255));
      if (pick < 450) begin
         kind = REQ_STREAM;
         if ($urandom_range(99) < 3) ch = CHAR_NL;
         else if ($urandom_range(99) < 3) ch = CHAR_CR;
      end else if (pick < 600) begin
         kind = REQ_CHAR_AT;
      end else if (pick < 680) begin
         kind = REQ_SET_CUR;
      end else if (pick < 920) begin
         kind = REQ_READ_CELL;
         // half the reads look at the cell before the cursor (column 0 when the cursor is there)
         if ($urandom_range(1) == 1) begin
            row = 8'(cur_row);
            col = (cur_col == 0) ? 8'd0 : 8'(cur_col - 1);
         end
      end else if (pick < 930) begin
         kind = REQ_CLEAR;
      end else if (pick < 940) begin
         kind = REQ_FILL;
      end else if (pick < 970) begin
         kind = REQ_SPARE_A;
      end else begin
         kind = REQ_SPARE_B;
      end
      send_req(kind, row, col, ch, 4'($urandom_range(15)), 4'($urandom_range(15)));
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      send_req(REQ_READ_CELL, 8'd0, 8'd0, 8'h00, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, 8'h48, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, 8'h00, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, 8'hFF, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, CHAR_CR, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, CHAR_NL, 4'h0, 4'h0);
      send_req(REQ_READ_CELL, 8'd0, 8'd1, 8'h00, 4'h0, 4'h0);
      send_req(REQ_CHAR_AT, 8'(ROWS - 1), 8'(COLS - 1), 8'h5A, 4'hF, 4'hF);
      // position writes outside the store are dropped
      send_req(REQ_CHAR_AT, 8'(ROWS), 8'd0, 8'h41, 4'h1, 4'h2);
      send_req(REQ_CHAR_AT, 8'd0, 8'(COLS), 8'h42, 4'h3, 4'h4);
      send_req(REQ_CHAR_AT, 8'hFF, 8'hFF, 8'h43, 4'h5, 4'h6);
      send_req(REQ_READ_CELL, 8'(ROWS - 1), 8'(COLS - 1), 8'h00, 4'h0, 4'h0);
      send_req(REQ_READ_CELL, 8'(ROWS), 8'd0, 8'h00, 4'h0, 4'h0);
      send_req(REQ_READ_CELL, 8'd0, 8'(COLS), 8'h00, 4'h0, 4'h0);
      send_req(REQ_READ_CELL, 8'hFF, 8'hFF, 8'h00, 4'h0, 4'h0);
      // cursor set saturates, then a char at the corner wraps and scrolls
      send_req(REQ_SET_CUR, 8'hFF, 8'hFF, 8'h00, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, 8'h71, 4'h0, 4'h0);
      send_req(REQ_READ_CELL, 8'(ROWS - 2), 8'(COLS - 1), 8'h00, 4'h0, 4'h0);
      send_req(REQ_SET_CUR, 8'(ROWS - 1), 8'd0, 8'h00, 4'h0, 4'h0);
      send_req(REQ_STREAM, 8'd0, 8'd0, CHAR_NL, 4'h0, 4'h0);
      send_req(REQ_SPARE_A, 8'd3, 8'd4, 8'h61, 4'h7, 4'h8);
      send_req(REQ_SPARE_B, 8'd5, 8'd6, 8'h62, 4'h9, 4'hA);
      send_req(REQ_FILL, 8'd0, 8'd0, 8'h00, 4'h5, 4'hA);
      send_req(REQ_READ_CELL, 8'd12, 8'd40, 8'h00, 4'h0, 4'h0);
      send_req(REQ_CLEAR, 8'd0, 8'd0, 8'h00, 4'h0, 4'h0);
      send_req(REQ_READ_CELL, 8'd0, 8'd0, 8'h00, 4'h0, 4'h0);
   endtask

   task automatic test_text_color();
      logic [7:0] colors [4];
      colors = '{8'h00, 8'hFF, 8'hA5, RESET_COLOR};
      foreach (colors[k]) begin
         write_color(colors[k]);
         send_req(REQ_SET_CUR, 8'(ROWS - 1), 8'(COLS - 2), 8'h00, 4'h0, 4'h0);
         send_req(REQ_STREAM, 8'd0, 8'd0, 8'h31, 4'h0, 4'h0);
         send_req(REQ_STREAM, 8'd0, 8'd0, 8'h32, 4'h0, 4'h0);
         send_req(REQ_STREAM, 8'd0, 8'd0, 8'h33, 4'h0, 4'h0);
         send_req(REQ_READ_CELL, 8'(ROWS - 2), 8'(COLS - 1), 8'h00, 4'h0, 4'h0);
         send_req(REQ_READ_CELL, 8'(ROWS - 1), 8'd0, 8'h00, 4'h0, 4'h0);
         send_req(REQ_READ_CELL, 8'(ROWS - 1), 8'd1, 8'h00, 4'h0, 4'h0);
         send_req(REQ_CLEAR, 8'd0, 8'd0, 8'h00, 4'h0, 4'h0);
         send_req(REQ_READ_CELL, 8'd10, 8'd10, 8'h00, 4'h0, 4'h0);
      end
   endtask

   task automatic test_output_stall();
      // the response side holds off while requests keep coming
      rsp_hold_left = HOLD_LONG;
      repeat (20) send_random_req();
   endtask

   task automatic test_sender_pause();
      repeat (6) send_random_req();
      wait_results_drained();
      repeat (6) send_random_req();
   endtask

   task automatic test_random();
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 250 == 249) write_color(8'($urandom_range(255)));
         if (i == 400) no_idle = 1'b1;
         if (i == 650) no_idle = 1'b0;
         send_random_req();
      end
   endtask

   // ---------------------------------------------------------------- response side
   initial begin : rsp_side
      cell_report_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (cell_report_q.size() == 0) begin
               $display("%0t unexpected response beat %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = cell_report_q.pop_front();
               if (rsp_tdata[15:0] !== want.cell_val) begin
                  $display("%0t cell_data expected %h got %h", $time, want.cell_val,
                           rsp_tdata[15:0]);
                  mismatches++;
               end
               if (rsp_tdata[20:16] !== want.crow) begin
                  $display("%0t cursor_row expected %0d got %0d", $time, want.crow,
                           rsp_tdata[20:16]);
                  mismatches++;
               end
               if (rsp_tdata[27:21] !== want.ccol) begin
                  $display("%0t cursor_col expected %0d got %0d", $time, want.ccol,
                           rsp_tdata[27:21]);
                  mismatches++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (!no_idle && $urandom_range(99) < 15) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ends the run when no beat moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
         $display("tb_text_console_writer_core NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      console_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_text_color();
      test_output_stall();
      test_sender_pause();
      test_random();
      wait_results_drained();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_text_console_writer_core OK");
      end else begin
         $display("tb_text_console_writer_core NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer_core.sv
tb/tb_text_console_writer_core.sv
